// ===== rtl/core/lsfg_pkg.sv =====
// Package for the LED strip frame generator: field layout, command codes,
// descriptor type passed from front end to word sequencer. No dependencies.
package lsfg_pkg;

    localparam int STRIP_LEDS     = 7;
    localparam int PIXEL_FIELDS   = 7;
    localparam int MAX_WHITE_LEDS = 62;
    localparam int ANIM_BITS      = 10;
    localparam int ANIM_FRAMES    = 1 << ANIM_BITS;
    localparam int STEPS          = 2 * (STRIP_LEDS - 1);
    localparam int QUEUE_DEPTH    = 2;

    localparam int CMD_W   = 2;
    localparam int FRAME_W = 16;
    localparam int COUNT_W = 6;
    localparam int PIX_W   = 24;
    localparam int WORD_W  = 32;
    localparam int IDX_W   = 6;

    localparam int FRAME_LSB = 0;
    localparam int COUNT_LSB = FRAME_LSB + FRAME_W;
    localparam int PIX_LSB   = COUNT_LSB + COUNT_W;
    localparam int IN_BITS   = PIX_LSB + PIXEL_FIELDS * PIX_W;
    localparam int S_DATA_W  = ((IN_BITS + 7) / 8) * 8;

    localparam logic [CMD_W-1:0] CMD_SCAN  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FB    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_WHITE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE  = 2'd3;

    localparam logic [WORD_W-1:0] START_WORD = 32'h0000_0000;
    localparam logic [WORD_W-1:0] END_WORD   = 32'hFFFF_FFFF;
    localparam logic [7:0]        HDR_BITS   = 8'hE0;
    localparam logic [7:0]        FULL_HDR   = 8'hFF;

    typedef enum logic [1:0] {
        KIND_SCAN,
        KIND_FB,
        KIND_WHITE
    } kind_t;

    typedef struct packed {
        kind_t                                kind;
        logic [IDX_W-1:0]                     pos;
        logic [IDX_W-1:0]                     nleds;
        logic [PIXEL_FIELDS-1:0][PIX_W-1:0]   pixels;
    } desc_t;

endpackage

// ===== rtl/core/lsfg_front.sv =====
// Front end: accepts frame requests, decodes the mode, computes the scanner
// position and the LED word count. Depends on lsfg_pkg.
module lsfg_front (
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [lsfg_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic [lsfg_pkg::CMD_W-1:0]     s_tuser,
    output logic                           push_valid,
    input  logic                           push_ready,
    output lsfg_pkg::desc_t                push_desc
);

    localparam int PROD_W = lsfg_pkg::ANIM_BITS + lsfg_pkg::IDX_W;

    logic [lsfg_pkg::FRAME_W-1:0] frame;
    logic [lsfg_pkg::COUNT_W-1:0] count;
    logic [PROD_W-1:0]            prod;
    logic [lsfg_pkg::IDX_W-1:0]   step;
    logic [lsfg_pkg::IDX_W-1:0]   white_n;

    assign s_tready   = push_ready;
    assign push_valid = s_tvalid && (s_tuser != lsfg_pkg::CMD_NONE);

    always_comb begin
        frame   = s_tdata[lsfg_pkg::FRAME_LSB +: lsfg_pkg::FRAME_W];
        count   = s_tdata[lsfg_pkg::COUNT_LSB +: lsfg_pkg::COUNT_W];
        // frame mod ANIM_FRAMES, scaled to STEPS positions
        prod    = PROD_W'(frame[lsfg_pkg::ANIM_BITS-1:0]) * PROD_W'(lsfg_pkg::STEPS);
        step    = prod[PROD_W-1:lsfg_pkg::ANIM_BITS];
        white_n = (count > lsfg_pkg::COUNT_W'(lsfg_pkg::MAX_WHITE_LEDS)) ?
                  lsfg_pkg::IDX_W'(lsfg_pkg::MAX_WHITE_LEDS) : lsfg_pkg::IDX_W'(count);

        push_desc.pos = (step <= lsfg_pkg::IDX_W'(lsfg_pkg::STRIP_LEDS - 1)) ?
                        step : lsfg_pkg::IDX_W'(lsfg_pkg::STEPS) - step;
        for (int k = 0; k < lsfg_pkg::PIXEL_FIELDS; k++) begin
            push_desc.pixels[k] =
                s_tdata[lsfg_pkg::PIX_LSB + k * lsfg_pkg::PIX_W +: lsfg_pkg::PIX_W];
        end

        unique case (s_tuser)
            lsfg_pkg::CMD_SCAN: begin
                push_desc.kind  = lsfg_pkg::KIND_SCAN;
                push_desc.nleds = lsfg_pkg::IDX_W'(lsfg_pkg::STRIP_LEDS);
            end
            lsfg_pkg::CMD_FB: begin
                push_desc.kind  = lsfg_pkg::KIND_FB;
                push_desc.nleds = lsfg_pkg::IDX_W'(lsfg_pkg::STRIP_LEDS);
            end
            lsfg_pkg::CMD_WHITE: begin
                push_desc.kind  = lsfg_pkg::KIND_WHITE;
                push_desc.nleds = white_n;
            end
            lsfg_pkg::CMD_NONE: begin
                push_desc.kind  = lsfg_pkg::KIND_WHITE;
                push_desc.nleds = '0;
            end
        endcase
    end

endmodule

// ===== rtl/core/lsfg_queue.sv =====
// Short descriptor queue between front end and word sequencer.
// Depends on lsfg_pkg.
module lsfg_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  lsfg_pkg::desc_t  push_desc,
    output logic             pop_valid,
    input  logic             pop,
    output lsfg_pkg::desc_t  pop_desc
);

    localparam int PTR_W = (lsfg_pkg::QUEUE_DEPTH > 1) ? $clog2(lsfg_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(lsfg_pkg::QUEUE_DEPTH + 1);

    lsfg_pkg::desc_t  mem_reg [lsfg_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign push_ready = (cnt_reg != CNT_W'(lsfg_pkg::QUEUE_DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_desc   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(lsfg_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(lsfg_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + PTR_W'(1);
        end
        cnt_next = cnt_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

// ===== rtl/core/lsfg_back.sv =====
// Word sequencer: walks start, LED and end words of the head descriptor,
// one per cycle unless stalled, into m_tdata_reg. Depends on lsfg_pkg.
module lsfg_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    input  lsfg_pkg::desc_t               q_desc,
    output logic                          q_pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [lsfg_pkg::WORD_W-1:0]   m_tdata,
    output logic                          m_tlast
);

    localparam int PSEL_W = (lsfg_pkg::PIXEL_FIELDS > 1) ? $clog2(lsfg_pkg::PIXEL_FIELDS) : 1;

    logic [lsfg_pkg::IDX_W-1:0]  cnt_reg, cnt_next;
    logic                        m_tvalid_reg, m_tvalid_next;
    logic [lsfg_pkg::WORD_W-1:0] m_tdata_reg, word_next;
    logic                        m_tlast_reg, last_next;
    logic                        advance, fire;
    logic [lsfg_pkg::IDX_W-1:0]  led;
    logic [lsfg_pkg::IDX_W-1:0]  led_gap;
    logic [4:0]                  br;
    logic [lsfg_pkg::PIX_W-1:0]  px;

    assign advance  = !m_tvalid_reg || m_tready;
    assign fire     = advance && q_valid;
    assign q_pop    = fire && last_next;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    always_comb begin
        led     = cnt_reg - lsfg_pkg::IDX_W'(1);
        led_gap = (led >= q_desc.pos) ? led - q_desc.pos : q_desc.pos - led;
        unique case (led_gap)
            lsfg_pkg::IDX_W'(0): br = 5'd31;
            lsfg_pkg::IDX_W'(1): br = 5'd8;
            lsfg_pkg::IDX_W'(2): br = 5'd2;
            default:             br = 5'd0;
        endcase
        px = (led < lsfg_pkg::IDX_W'(lsfg_pkg::PIXEL_FIELDS)) ?
             q_desc.pixels[led[PSEL_W-1:0]] : '0;

        last_next = (cnt_reg == q_desc.nleds + lsfg_pkg::IDX_W'(1));
        if (cnt_reg == '0) begin
            word_next = lsfg_pkg::START_WORD;
        end else if (last_next) begin
            word_next = lsfg_pkg::END_WORD;
        end else begin
            unique case (q_desc.kind)
                lsfg_pkg::KIND_SCAN:
                    word_next = {lsfg_pkg::HDR_BITS | {3'b000, br}, 16'h0000,
                                 (br != 5'd0) ? 8'hFF : 8'h00};
                lsfg_pkg::KIND_FB:
                    word_next = {lsfg_pkg::FULL_HDR, px[7:0], px[15:8], px[23:16]};
                default:
                    word_next = lsfg_pkg::END_WORD;
            endcase
        end

        cnt_next      = cnt_reg;
        m_tvalid_next = m_tvalid_reg;
        if (advance) begin
            m_tvalid_next = q_valid;
        end
        if (fire) begin
            cnt_next = last_next ? '0 : cnt_reg + lsfg_pkg::IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_tdata_reg <= word_next;
            m_tlast_reg <= last_next;
        end
    end

endmodule

// ===== rtl/core/led_strip_frame_generator_unit.sv =====
// LED strip frame generator top level: front end, descriptor queue and word
// sequencer. Depends on lsfg_pkg, lsfg_front, lsfg_queue, lsfg_back.
// The start word passes the descriptor queue, then the output register, to m_tdata.
// The word sequencer sends one word per cycle unless stalled; a request gives
// STRIP_LEDS+2 words (9) in scanner and framebuffer mode, min(led_count,62)+2 in white.
// Reset: synchronous active-low aresetn empties the queue and clears m_tvalid.
module led_strip_frame_generator_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // frame[15:0], led_count[21:16], pixel_0..pixel_6 24 bits each from bit 22
    input  logic [lsfg_pkg::S_DATA_W-1:0] s_tdata,
    // cmd[1:0]
    input  logic [lsfg_pkg::CMD_W-1:0]    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // word[31:0]
    output logic [lsfg_pkg::WORD_W-1:0]   m_tdata,
    output logic                          m_tlast
);

    logic            push_valid, push_ready;
    lsfg_pkg::desc_t push_desc;
    logic            q_valid, q_pop;
    lsfg_pkg::desc_t q_desc;

    lsfg_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_desc  (push_desc)
    );

    lsfg_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_desc  (push_desc),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_desc   (q_desc)
    );

    lsfg_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_desc   (q_desc),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== rtl/core/lsfg_checker.sv =====
// Port-level checker for the LED strip frame generator and its bind.
// Depends on lsfg_pkg and led_strip_frame_generator_unit.
module lsfg_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [lsfg_pkg::WORD_W-1:0]   m_tdata,
    input logic                          m_tlast
);

    logic       expect_start_reg;
    logic [6:0] words_reg;
    logic       m_xfer;

    assign m_xfer = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expect_start_reg <= 1'b1;
            words_reg        <= '0;
        end else if (m_xfer) begin
            expect_start_reg <= m_tlast;
            words_reg        <= m_tlast ? 7'd0 : words_reg + 7'd1;
        end
    end

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output transaction changed");

    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && expect_start_reg |-> m_tdata == lsfg_pkg::START_WORD && !m_tlast)
        else $error("frame does not open with start word");

    a_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata == lsfg_pkg::END_WORD && !expect_start_reg)
        else $error("bad end word");

    a_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> words_reg < 7'd64)
        else $error("frame longer than 64 words");

endmodule

bind led_strip_frame_generator_unit lsfg_checker u_lsfg_checker (.*);
